@@ rtl/core/ttb_pkg.sv @@
// ----------------------------------------------------------------------------
// Translation table builder package
// Shared widths, codes and descriptor helpers for the table builder.
// ----------------------------------------------------------------------------
package ttb_pkg;

    localparam int StoreWords = 524288;
    localparam int WordBits   = $clog2(StoreWords);
    localparam int TableWords = 512;
    localparam int IdBlocks   = 1 << 18;

    localparam logic [63:0] AddrMask = 64'h0000_ffff_ffff_f000;
    localparam logic [63:0] KeepMask = 64'hfffc_0000_0000_0ffc;

    localparam logic [1:0] ModeInit   = 2'd0;
    localparam logic [1:0] ModeMap    = 2'd1;
    localparam logic [1:0] ModeLookup = 2'd2;
    localparam logic [1:0] ModeNop    = 2'd3;

    localparam logic [1:0] StatDone  = 2'd0;
    localparam logic [1:0] StatSpace = 2'd1;
    localparam logic [1:0] StatBad   = 2'd2;

    // Address bit position of the index field at a level.
    function automatic logic [5:0] lvl_shift(input logic [1:0] lvl);
        unique case (lvl)
            2'd0:    lvl_shift = 6'd39;
            2'd1:    lvl_shift = 6'd30;
            2'd2:    lvl_shift = 6'd21;
            default: lvl_shift = 6'd12;
        endcase
    endfunction

    function automatic logic [8:0] lvl_index(input logic [47:0] a, input logic [1:0] lvl);
        logic [47:0] s;
        s = a >> lvl_shift(lvl);
        lvl_index = s[8:0];
    endfunction

    // Mask that keeps the output address bits above a level's span.
    function automatic logic [63:0] lvl_clear(input logic [1:0] lvl);
        lvl_clear = AddrMask & ~((64'd1 << lvl_shift(lvl)) - 64'd1);
    endfunction

endpackage

@@ rtl/core/ttb_store.sv @@
// ----------------------------------------------------------------------------
// Descriptor store
// Single-port synchronous word memory; read data is registered from the address.
// ----------------------------------------------------------------------------
module ttb_store (
    input  logic                         aclk,
    input  logic                         we,
    input  logic [ttb_pkg::WordBits-1:0] addr,
    input  logic [63:0]                  wdata,
    output logic [63:0]                  rdata
);

    logic [63:0] mem [ttb_pkg::StoreWords];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ rtl/core/translation_table_builder_top.sv @@
// ----------------------------------------------------------------------------
// Translation table builder
// Builds and walks 4-level 4 KiB-granule descriptor tables held in one store.
// ----------------------------------------------------------------------------
// A lookup reads the store once per level (ST_RD, ST_WAIT, ST_EVAL); init
// writes one store word a cycle, 512 level-0 table pointers and 2^18 level-1
// blocks; map walks each block down the levels and splits blocks on its way.
// One item at a time; the next is taken after the result leaves.
// Reset (synchronous, aresetn low) clears control, base_reg and the
// allocator (512); the store keeps its contents and needs no clearing pass.
module translation_table_builder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [47:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [47:0] s_start_address,
    input  logic [48:0] s_end_address,
    input  logic [3:0]  s_attr_index,
    input  logic [1:0]  s_shareability,
    input  logic        s_no_execute,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [63:0] m_found_desc,
    output logic [1:0]  m_found_lvl
);

    localparam int WB = ttb_pkg::WordBits;

    typedef enum logic [3:0] {
        ST_IDLE, ST_INIT_L0, ST_INIT_L1, ST_MAP_NEXT, ST_RD, ST_WAIT, ST_EVAL,
        ST_SPLIT, ST_LEAF, ST_OUT
    } state_t;

    state_t       state_reg;
    logic [47:0]  base_reg;
    logic [WB:0]  free_reg;
    logic [1:0]   mode_reg;
    logic [47:0]  start_reg;
    logic [48:0]  size_reg;
    logic [63:0]  attrs_reg;
    logic [1:0]   lvl_reg, target_reg;
    logic [WB-1:0] w_reg, idx_reg, nw_reg;
    logic [18:0]  cnt_reg;
    logic [63:0]  sd_reg;
    logic [1:0]   stat_reg;
    logic [63:0]  leaf_reg;
    logic [1:0]   leaflvl_reg;

    logic          mem_we;
    logic [WB-1:0] mem_addr;
    logic [63:0]   mem_wdata, mem_rdata;

    ttb_store u_store (
        .aclk (aclk), .we (mem_we), .addr (mem_addr),
        .wdata (mem_wdata), .rdata (mem_rdata)
    );

    // Table pointer to word nw_reg and the reverse decode with range check.
    logic [47:0] tp_sum;
    logic [63:0] nw_ptr;
    assign tp_sum = base_reg + {{(48-WB-3){1'b0}}, nw_reg, 3'b000};
    assign nw_ptr = {16'd0, tp_sum & ttb_pkg::AddrMask[47:0]} | 64'd3;

    logic [47:0] off;
    logic        tw_ok;
    assign off   = (mem_rdata[47:0] & ttb_pkg::AddrMask[47:0]) - base_reg;
    assign tw_ok = ((off & ttb_pkg::AddrMask[47:0]) >> 3)
                   <= 48'(ttb_pkg::StoreWords - ttb_pkg::TableWords);
    logic [WB-1:0] tw_word;
    assign tw_word = off[WB+2:3];

    // Block size choice for the next map step.
    logic [1:0] pick;
    always_comb begin
        if (start_reg[29:0] == '0)      pick = 2'd1;
        else if (start_reg[20:0] == '0) pick = 2'd2;
        else                            pick = 2'd3;
        if (pick == 2'd1 && size_reg < 49'(1) << 30) pick = 2'd2;
        if (pick == 2'd2 && size_reg < 49'(1) << 21) pick = 2'd3;
    end

    logic [63:0] split_word;
    logic [1:0]  lvl_inc;
    assign lvl_inc = lvl_reg + 2'd1;
    assign split_word = ((lvl_inc == 2'd3) ? 64'd3 : 64'd1) | (sd_reg & ttb_pkg::KeepMask)
        | (sd_reg & ttb_pkg::lvl_clear(lvl_reg))
        | ({55'd0, cnt_reg[8:0]} << ttb_pkg::lvl_shift(lvl_inc));

    logic [63:0] s_attrs;
    assign s_attrs = ({61'd0, s_attr_index[2:0]} << 2) | ({62'd0, s_shareability} << 8)
        | (64'd1 << 10) | ({63'd0, s_no_execute} << 54) | ({63'd0, s_attr_index[3]} << 59);

    logic [48:0] e_sat, e_end;
    always_comb begin
        e_sat = (s_end_address > 49'h1_0000_0000_0000) ? 49'h1_0000_0000_0000
                                                        : s_end_address;
        e_end = (e_sat + 49'hfff) & ~49'hfff;
    end
    logic [48:0] s_al;
    assign s_al = {1'b0, s_start_address & ttb_pkg::AddrMask[47:0]};

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = idx_reg;
        mem_wdata = '0;
        unique case (state_reg)
            ST_INIT_L0: begin
                mem_we    = 1'b1;
                mem_addr  = WB'(cnt_reg);
                mem_wdata = nw_ptr;
            end
            ST_INIT_L1: begin
                mem_we    = 1'b1;
                mem_addr  = WB'(ttb_pkg::TableWords) + WB'(cnt_reg);
                mem_wdata = 64'h605 | ({45'd0, cnt_reg} << 30);
            end
            ST_RD: mem_addr = w_reg + WB'(ttb_pkg::lvl_index(start_reg, lvl_reg));
            ST_SPLIT: begin
                mem_we = 1'b1;
                if (cnt_reg[9]) begin
                    mem_addr  = idx_reg;
                    mem_wdata = nw_ptr;
                end else begin
                    mem_addr  = nw_reg + WB'(cnt_reg[8:0]);
                    mem_wdata = split_word;
                end
            end
            ST_LEAF: begin
                mem_we    = 1'b1;
                mem_addr  = w_reg + WB'(ttb_pkg::lvl_index(start_reg, target_reg));
                mem_wdata = ((target_reg == 2'd3) ? 64'd3 : 64'd1)
                          | {16'd0, start_reg} | attrs_reg;
            end
            default: ;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_status = stat_reg;
    assign m_found_desc = leaf_reg;
    assign m_found_lvl = leaflvl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            base_reg  <= '0;
            free_reg  <= (WB+1)'(ttb_pkg::TableWords);
        end else begin
            if (cfg_we) base_reg <= cfg_wdata & ttb_pkg::AddrMask[47:0];
            unique case (state_reg)
                ST_IDLE: if (s_valid) begin
                    mode_reg  <= s_mode;
                    start_reg <= s_al[47:0];
                    attrs_reg <= s_attrs;
                    size_reg  <= e_end - s_al;
                    stat_reg  <= ttb_pkg::StatDone;
                    leaf_reg  <= '0;
                    leaflvl_reg <= '0;
                    cnt_reg   <= '0;
                    nw_reg    <= WB'(ttb_pkg::TableWords);
                    w_reg     <= '0;
                    lvl_reg   <= '0;
                    unique case (s_mode)
                        ttb_pkg::ModeInit: begin
                            free_reg  <= (WB+1)'(ttb_pkg::TableWords);
                            state_reg <= ST_INIT_L0;
                        end
                        ttb_pkg::ModeMap:
                            state_reg <= (e_end <= s_al) ? ST_OUT : ST_MAP_NEXT;
                        // The page offset never reaches an index field, so the
                        // aligned address serves the walk.
                        ttb_pkg::ModeLookup: state_reg <= ST_RD;
                        default: state_reg <= ST_OUT;
                    endcase
                end
                ST_INIT_L0: begin
                    nw_reg <= nw_reg + WB'(ttb_pkg::TableWords);
                    if (cnt_reg == 19'(ttb_pkg::TableWords - 1)) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_INIT_L1;
                    end else begin
                        cnt_reg <= cnt_reg + 19'd1;
                    end
                end
                ST_INIT_L1: begin
                    cnt_reg <= cnt_reg + 19'd1;
                    if (cnt_reg == 19'(ttb_pkg::IdBlocks - 1)) begin
                        free_reg  <= (WB+1)'(ttb_pkg::TableWords + ttb_pkg::IdBlocks);
                        state_reg <= ST_OUT;
                    end
                end
                ST_MAP_NEXT: begin
                    if (size_reg == '0) begin
                        state_reg <= ST_OUT;
                    end else begin
                        target_reg <= pick;
                        lvl_reg    <= '0;
                        w_reg      <= '0;
                        state_reg  <= ST_RD;
                    end
                end
                ST_RD: begin
                    idx_reg   <= mem_addr;
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: state_reg <= ST_EVAL;
                ST_EVAL: begin
                    sd_reg <= mem_rdata;
                    if (mode_reg == ttb_pkg::ModeLookup) begin
                        if (lvl_reg == 2'd0 && mem_rdata[1:0] != 2'd3) begin
                            stat_reg  <= ttb_pkg::StatBad;
                            state_reg <= ST_OUT;
                        end else if (lvl_reg != 2'd3 && mem_rdata[1:0] == 2'd3) begin
                            if (!tw_ok) begin
                                stat_reg  <= ttb_pkg::StatBad;
                                state_reg <= ST_OUT;
                            end else begin
                                w_reg     <= tw_word;
                                lvl_reg   <= lvl_inc;
                                state_reg <= ST_RD;
                            end
                        end else begin
                            leaf_reg    <= mem_rdata;
                            leaflvl_reg <= lvl_reg;
                            state_reg   <= ST_OUT;
                        end
                    end else if (mem_rdata[1:0] == 2'd3) begin
                        if (!tw_ok) begin
                            stat_reg  <= ttb_pkg::StatBad;
                            state_reg <= ST_OUT;
                        end else begin
                            w_reg     <= tw_word;
                            lvl_reg   <= lvl_inc;
                            state_reg <= (lvl_inc == target_reg) ? ST_LEAF : ST_RD;
                        end
                    end else if (lvl_reg != 2'd0 && mem_rdata[1:0] == 2'd1) begin
                        if (free_reg + (WB+1)'(ttb_pkg::TableWords)
                                > (WB+1)'(ttb_pkg::StoreWords)) begin
                            stat_reg  <= ttb_pkg::StatSpace;
                            state_reg <= ST_OUT;
                        end else begin
                            nw_reg    <= free_reg[WB-1:0];
                            free_reg  <= free_reg + (WB+1)'(ttb_pkg::TableWords);
                            cnt_reg   <= '0;
                            state_reg <= ST_SPLIT;
                        end
                    end else begin
                        stat_reg  <= ttb_pkg::StatBad;
                        state_reg <= ST_OUT;
                    end
                end
                ST_SPLIT: begin
                    cnt_reg <= cnt_reg + 19'd1;
                    if (cnt_reg[9]) begin
                        w_reg     <= nw_reg;
                        lvl_reg   <= lvl_inc;
                        state_reg <= (lvl_inc == target_reg) ? ST_LEAF : ST_RD;
                    end
                end
                ST_LEAF: begin
                    start_reg <= start_reg + (48'd1 << ttb_pkg::lvl_shift(target_reg));
                    size_reg  <= size_reg - (49'd1 << ttb_pkg::lvl_shift(target_reg));
                    state_reg <= ST_MAP_NEXT;
                end
                ST_OUT: if (m_ready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // The allocator never hands out words past the end of the store.
    assert property (@(posedge aclk) disable iff (!aresetn)
        free_reg <= (WB+1)'(ttb_pkg::StoreWords))
        else $error("allocator beyond store");
    // A finished item holds its result until taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result dropped");
    // Errors never carry a leaf.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ttb_pkg::StatDone |-> m_found_desc == '0)
        else $error("leaf on error");
`endif

endmodule
